// ===== hdl/mslbc_pkg.sv =====
package mslbc_pkg;

  localparam int MAX_FLIPS_DEF = 12;
  localparam int LONG_BITS     = 112;
  localparam int HALF_BITS     = 56;
  localparam logic [24:0] GEN_POLY = 25'h1FFF409;

  typedef enum logic [1:0] {
    FIX_PASS      = 2'd0,
    FIX_CORRECTED = 2'd1,
    FIX_MULTI     = 2'd2,
    FIX_NONE      = 2'd3
  } fix_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_SEARCH,
    ST_FIX,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [55:0] frame_hi;
    logic [55:0] frame_lo;
    logic [55:0] conf_hi;
    logic [55:0] conf_lo;
    logic        is_long;
    logic        crc_good_in;
    logic        fixed_before;
    logic [23:0] address_in;
  } in_word_t;

  typedef struct packed {
    logic [55:0] out_hi;
    logic [55:0] out_lo;
    logic [23:0] address_out;
    fix_status_t fix_status;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic search_init;
    logic search;
    logic fix;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic bypass;
    logic scan_done;
    logic cnt_zero;
    logic too_many;
    logic search_done;
    logic out_free;
  } sts_t;

  typedef logic [23:0] syn_tab_t [LONG_BITS];

  // syndrome of a single bit at frame position pos of a long frame
  function automatic logic [23:0] bit_syn(input int pos);
    logic [24:0] c;
    c = 25'd1;
    for (int k = pos; k < LONG_BITS - 1; k++) begin
      c = c << 1;
      if (c[24]) c = c ^ GEN_POLY;
    end
    return c[23:0];
  endfunction

  function automatic syn_tab_t build_tab();
    syn_tab_t t;
    for (int p = 0; p < LONG_BITS; p++) t[p] = bit_syn(p);
    return t;
  endfunction

  localparam syn_tab_t SYN_TAB = build_tab();

endpackage

// ===== hdl/mslbc_ctrl.sv =====
module mslbc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mslbc_pkg::sts_t   sts,
  output mslbc_pkg::cmd_t   cmd
);

  mslbc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mslbc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      mslbc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = mslbc_pkg::ST_SCAN;
        end
      end
      mslbc_pkg::ST_SCAN: begin
        if (sts.bypass) begin
          state_nxt = mslbc_pkg::ST_DONE;
        end else begin
          cmd.scan = 1'b1;
          if (sts.scan_done) state_nxt = mslbc_pkg::ST_CHECK;
        end
      end
      mslbc_pkg::ST_CHECK: begin
        if (sts.cnt_zero || sts.too_many) begin
          state_nxt = mslbc_pkg::ST_DONE;
        end else begin
          cmd.search_init = 1'b1;
          state_nxt       = mslbc_pkg::ST_SEARCH;
        end
      end
      mslbc_pkg::ST_SEARCH: begin
        cmd.search = 1'b1;
        if (sts.search_done) state_nxt = mslbc_pkg::ST_FIX;
      end
      mslbc_pkg::ST_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = mslbc_pkg::ST_DONE;
      end
      mslbc_pkg::ST_DONE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = mslbc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mslbc_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/mslbc_dp.sv =====
module mslbc_dp #(
  parameter int MAX_FLIPS = mslbc_pkg::MAX_FLIPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mslbc_pkg::in_word_t  in_data,
  input  mslbc_pkg::cmd_t      cmd,
  output mslbc_pkg::sts_t      sts,
  input  logic                 out_ready,
  output logic                 out_valid,
  output mslbc_pkg::out_word_t out_data
);

  localparam int CW = $clog2(MAX_FLIPS + 2);

  logic [111:0]         frame_r, frame_nxt;
  logic [111:0]         conf_r;
  logic                 long_r;
  logic                 bypass_r;
  logic [23:0]          addr_r;
  logic [6:0]           p_r;
  logic [CW-1:0]        cnt_r;
  logic [6:0]           pos_r [MAX_FLIPS];
  logic [23:0]          syn_r [MAX_FLIPS];
  logic [23:0]          err_r;
  logic [MAX_FLIPS-1:0] code_r;
  logic [MAX_FLIPS-1:0] corr_r;
  logic [1:0]           found_r;
  logic                 outv_r;
  mslbc_pkg::out_word_t out_r;

  logic [6:0]           tidx;
  logic [6:0]           last_pos;
  logic                 fbit;
  logic                 cbit;
  logic [23:0]          cand_syn;
  logic                 match;
  logic [MAX_FLIPS-1:0] code_init;
  logic [111:0]         flip_mask;
  mslbc_pkg::out_word_t out_nxt;

  assign tidx     = p_r + (long_r ? 7'd0 : 7'd56);
  assign last_pos = long_r ? 7'd111 : 7'd55;
  assign fbit     = frame_r[7'd111 - p_r];
  assign cbit     = conf_r[7'd111 - p_r];

  // xor of the single-bit syndromes picked by the current code
  always_comb begin
    cand_syn = '0;
    for (int j = 0; j < MAX_FLIPS; j++) begin
      if (code_r[j]) cand_syn = cand_syn ^ syn_r[j];
    end
  end

  assign match = (cand_syn == err_r);

  always_comb begin
    for (int k = 0; k < MAX_FLIPS; k++) begin
      code_init[k] = (CW'(k) < cnt_r);
    end
  end

  always_comb begin
    flip_mask = '0;
    for (int j = 0; j < MAX_FLIPS; j++) begin
      if (corr_r[j]) flip_mask[7'd111 - pos_r[j]] = 1'b1;
    end
  end

  always_comb begin
    frame_nxt = frame_r;
    if (cmd.load) begin
      frame_nxt = {in_data.frame_hi, in_data.frame_lo};
    end else if (cmd.fix && found_r == 2'd1) begin
      frame_nxt = frame_r ^ flip_mask;
    end
  end

  always_comb begin
    out_nxt.out_hi      = frame_r[111:56];
    out_nxt.out_lo      = frame_r[55:0];
    out_nxt.address_out = addr_r;
    priority if (bypass_r || cnt_r == '0) begin
      out_nxt.fix_status = mslbc_pkg::FIX_PASS;
    end else if (cnt_r > CW'(MAX_FLIPS)) begin
      out_nxt.fix_status = mslbc_pkg::FIX_NONE;
    end else if (found_r == 2'd1) begin
      // a unique fix clears the syndrome, so the recomputed parity is zero
      out_nxt.fix_status  = mslbc_pkg::FIX_CORRECTED;
      out_nxt.address_out = '0;
    end else if (found_r == 2'd2) begin
      out_nxt.fix_status = mslbc_pkg::FIX_MULTI;
    end else begin
      out_nxt.fix_status = mslbc_pkg::FIX_NONE;
    end
  end

  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
    if (cmd.load) begin
      conf_r   <= {in_data.conf_hi, in_data.conf_lo};
      long_r   <= in_data.is_long;
      bypass_r <= in_data.crc_good_in | in_data.fixed_before;
      addr_r   <= in_data.address_in;
      p_r      <= '0;
      cnt_r    <= '0;
      err_r    <= '0;
      found_r  <= '0;
      corr_r   <= '0;
    end
    if (cmd.scan) begin
      p_r <= p_r + 7'd1;
      if (fbit) err_r <= err_r ^ mslbc_pkg::SYN_TAB[tidx];
      if (cbit) begin
        // count saturates just past the limit
        if (cnt_r != CW'(MAX_FLIPS + 1)) cnt_r <= cnt_r + CW'(1);
        for (int k = 0; k < MAX_FLIPS; k++) begin
          if (cnt_r == CW'(k)) begin
            pos_r[k] <= p_r;
            syn_r[k] <= mslbc_pkg::SYN_TAB[tidx];
          end
        end
      end
    end
    if (cmd.search_init) code_r <= code_init;
    if (cmd.search) begin
      code_r <= code_r - MAX_FLIPS'(1);
      if (match) begin
        corr_r <= code_r;
        if (found_r != 2'd2) found_r <= found_r + 2'd1;
      end
    end
    if (cmd.emit) out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outv_r <= 1'b0;
    end else if (cmd.emit) begin
      outv_r <= 1'b1;
    end else if (out_ready) begin
      outv_r <= 1'b0;
    end
  end

  assign sts.bypass      = bypass_r;
  assign sts.scan_done   = (p_r == last_pos);
  assign sts.cnt_zero    = (cnt_r == '0);
  assign sts.too_many    = (cnt_r > CW'(MAX_FLIPS));
  assign sts.search_done = (code_r == MAX_FLIPS'(1)) || (match && found_r != 2'd0);
  assign sts.out_free    = !outv_r || out_ready;

  assign out_valid = outv_r;
  assign out_data  = out_r;

endmodule

// ===== hdl/mode_s_lowconf_bit_corrector_top.sv =====
// Mode S low-confidence bit corrector. One frame word is taken at a time: crc-good,
// already-fixed and unflagged frames pass with status 0; otherwise the flagged bits
// (up to MAX_FLIPS) are searched exhaustively for a flip set that cancels the 24-bit
// syndrome. A word that is not passed through for crc-good or already-fixed has its n
// frame bits (n = 56 or 112) scanned one per cycle to build the syndrome and the flag
// list; when a search runs, the candidate loop tries one code per cycle and stops early
// at the second match. The next word is accepted while a finished result still waits
// in the output register.
module mode_s_lowconf_bit_corrector_top #(
  parameter int MAX_FLIPS = mslbc_pkg::MAX_FLIPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mslbc_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mslbc_pkg::out_word_t out_data
);

  mslbc_pkg::cmd_t cmd;
  mslbc_pkg::sts_t sts;

  mslbc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mslbc_dp #(
    .MAX_FLIPS (MAX_FLIPS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
